// ===== hdl/grr_pkg.sv =====
package grr_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;
  localparam int SUBTILES_DEF    = 4;
  localparam int MAX_SIDE_DEF    = 16;

  localparam int FINE_W      = 10;
  localparam int RECT_W      = 5;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     MAP_SIZE_RST   = 9'd256;

  localparam logic FUNC_RESERVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_BOUNDS   = 2'd1,
    STATUS_CONFLICT = 2'd2
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic              oob;
    logic              func;
    logic [FINE_W-1:0] col;
    logic [FINE_W-1:0] row;
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
  } req_t;

endpackage

// ===== hdl/grr_ram.sv =====
module grr_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/grr_front.sv =====
module grr_front import grr_pkg::*; #(
  parameter int GRID_WIDTH        = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT       = GRID_HEIGHT_DEF,
  parameter int SUBTILES_PER_TILE = SUBTILES_DEF,
  parameter int MAX_RECT_SIDE     = MAX_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [FINE_W-1:0] fine_x_i,
  input  logic [FINE_W-1:0] fine_y_i,
  input  logic [RECT_W-1:0] rect_width_i,
  input  logic [RECT_W-1:0] rect_height_i,
  input  logic [CFG_W-1:0]  map_width_i,
  input  logic [CFG_W-1:0]  map_height_i,
  input  logic              clearing_i,
  output logic              push_o,
  output req_t              push_data_o,
  input  logic              full_i
);

  // divide by the sub-tile factor as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = FINE_W + $clog2(SUBTILES_PER_TILE) + 1;
  localparam int PROD_W    = FINE_W + DIV_SHIFT + 1;
  localparam logic [DIV_SHIFT:0] RECIP =
    (DIV_SHIFT+1)'(((1 << DIV_SHIFT) + SUBTILES_PER_TILE - 1) / SUBTILES_PER_TILE);
  localparam int BND_W = FINE_W + 1;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_func_q;
  logic [FINE_W-1:0] s1_fx_q, s1_fy_q;
  logic [RECT_W-1:0] s1_w_q, s1_h_q;

  logic              s2_valid_q, s2_valid_d;
  logic              s2_func_q;
  logic [FINE_W-1:0] s2_bx_q, s2_by_q;
  logic [RECT_W-1:0] s2_w_q, s2_h_q;

  logic              accept, s1_adv, s2_free, s1_free;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [BND_W-1:0]  mw_lim, mh_lim;
  logic              size_bad, x_bad, y_bad;

  assign push_o     = s2_valid_q && !full_i;
  assign s2_free    = !s2_valid_q || push_o;
  assign s1_adv     = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_free || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign s2_valid_d = s1_adv ? 1'b1 : (push_o ? 1'b0 : s2_valid_q);

  assign prod_x = PROD_W'(s1_fx_q) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(s1_fy_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= func_i;
      s1_fx_q   <= fine_x_i;
      s1_fy_q   <= fine_y_i;
      s1_w_q    <= rect_width_i;
      s1_h_q    <= rect_height_i;
    end
    if (s1_adv) begin
      s2_func_q <= s1_func_q;
      s2_bx_q   <= prod_x[DIV_SHIFT +: FINE_W];
      s2_by_q   <= prod_y[DIV_SHIFT +: FINE_W];
      s2_w_q    <= s1_w_q;
      s2_h_q    <= s1_h_q;
    end
  end

  // map size registers above the grid are clamped to the grid
  assign mw_lim = (BND_W'(map_width_i) > BND_W'(GRID_WIDTH)) ?
                  BND_W'(GRID_WIDTH) : BND_W'(map_width_i);
  assign mh_lim = (BND_W'(map_height_i) > BND_W'(GRID_HEIGHT)) ?
                  BND_W'(GRID_HEIGHT) : BND_W'(map_height_i);

  assign size_bad = (s2_w_q == '0) || (s2_h_q == '0) ||
                    (8'(s2_w_q) > 8'(MAX_RECT_SIDE)) ||
                    (8'(s2_h_q) > 8'(MAX_RECT_SIDE));
  assign x_bad = (BND_W'(s2_bx_q) + BND_W'(s2_w_q)) > mw_lim;
  assign y_bad = (BND_W'(s2_by_q) + BND_W'(s2_h_q)) > mh_lim;

  always_comb begin
    push_data_o.oob  = size_bad || x_bad || y_bad;
    push_data_o.func = s2_func_q;
    push_data_o.col  = s2_bx_q;
    push_data_o.row  = s2_by_q;
    push_data_o.w    = s2_w_q;
    push_data_o.h    = s2_h_q;
  end

endmodule

// ===== hdl/grr_queue.sv =====
module grr_queue import grr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output req_t data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/grr_back.sv =====
module grr_back import grr_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  req_t                q_data_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o
);

  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int LOW_W  = 1 << RECT_W;
  localparam int SPAN_W = GRID_WIDTH + LOW_W;
  localparam int SUM_W  = ROW_W + RECT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [RECT_W-1:0] cnt_q, cnt_d;
  logic [ROW_W-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  status_e           res_q, res_d;
  logic              func_q, func_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [RECT_W-1:0] h_q, h_d;
  logic [GRID_WIDTH-1:0] mask_q, mask_d;
  logic [ROW_W-1:0]  prev_q, prev_d;

  logic                  ram_we, ram_re;
  logic [ROW_W-1:0]      ram_waddr, ram_raddr;
  logic [GRID_WIDTH-1:0] ram_wdata, ram_rdata, merged;
  logic [SUM_W-1:0]      addr_sum;
  logic [LOW_W-1:0]      low_mask;
  logic [SPAN_W-1:0]     span;
  logic                  conflict;

  grr_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign addr_sum  = SUM_W'(row_q) + SUM_W'(cnt_q);
  assign ram_raddr = addr_sum[ROW_W-1:0];

  // a tile already holding the mark being written is a conflict
  assign conflict = (func_q == FUNC_RESERVE) ? |(ram_rdata & mask_q)
                                             : |(~ram_rdata & mask_q);
  assign merged   = (func_q == FUNC_RESERVE) ? (ram_rdata | mask_q)
                                             : (ram_rdata & ~mask_q);

  assign low_mask = ~({LOW_W{1'b1}} << q_data_i.w);
  assign span     = SPAN_W'(low_mask) << q_data_i.col[COL_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    res_d       = res_q;
    func_d      = func_q;
    row_d       = row_q;
    h_d         = h_q;
    mask_d      = mask_q;
    prev_d      = ram_raddr;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = prev_q;
    ram_wdata   = merged;
    pop_o       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ROW_W'(GRID_HEIGHT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o  = 1'b1;
          func_d = q_data_i.func;
          row_d  = q_data_i.row[ROW_W-1:0];
          h_d    = q_data_i.h;
          mask_d = span[GRID_WIDTH-1:0];
          cnt_d  = '0;
          if (q_data_i.oob) begin
            res_d   = STATUS_BOUNDS;
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // read row n while row n-1 is checked
        ram_re = cnt_q < h_q;
        if ((cnt_q != '0) && conflict) begin
          res_d   = STATUS_CONFLICT;
          state_d = ST_DONE;
        end else if (cnt_q == h_q) begin
          cnt_d   = '0;
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WRITE: begin
        // read row n while row n-1 is written back merged
        ram_re = cnt_q < h_q;
        ram_we = cnt_q != '0;
        if (cnt_q == h_q) begin
          res_d   = STATUS_DONE;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_DONE;
      res_q       <= STATUS_DONE;
      func_q      <= 1'b0;
      row_q       <= '0;
      h_q         <= '0;
      mask_q      <= '0;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      res_q       <= res_d;
      func_q      <= func_d;
      row_q       <= row_d;
      h_q         <= h_d;
      mask_q      <= mask_d;
      prev_q      <= prev_d;
    end
  end

  assign clearing_o  = state_q == ST_CLEAR;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_CHECK || state_q == ST_DONE) |-> !ram_we)
    else $error("map written outside clear or write phase");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

  a_write_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && ram_we) |-> $past(ram_re))
    else $error("row written back without a read the cycle before");
`endif

endmodule

// ===== hdl/grid_rectangle_reserver_core.sv =====
// status order: an out of bounds request reports soonest, as it skips the map passes;
//   a conflict skips the write pass, so it reports sooner than a done request
// requests: the back end works on one at a time, limited by the single read and write
//   port of the row-wide map memory (check pass then read-modify-write pass)
// reset: map size registers go to 256, then a clearing pass zeroes the map one row
//   a cycle while input is stalled
module grid_rectangle_reserver_core import grr_pkg::*; #(
  parameter int GRID_WIDTH        = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT       = GRID_HEIGHT_DEF,
  parameter int SUBTILES_PER_TILE = SUBTILES_DEF,
  parameter int MAX_RECT_SIDE     = MAX_SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [FINE_W-1:0]    fine_x_i,
  input  logic [FINE_W-1:0]    fine_y_i,
  input  logic [RECT_W-1:0]    rect_width_i,
  input  logic [RECT_W-1:0]    rect_height_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o
);

  logic [CFG_W-1:0] map_width_q, map_height_q;
  logic             clearing;
  logic             push, full, pop, empty;
  req_t             push_data, head_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_SIZE_RST;
      map_height_q <= MAP_SIZE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MAP_WIDTH) begin
        map_width_q <= cfg_data_i;
      end else if (cfg_index_i == REG_MAP_HEIGHT) begin
        map_height_q <= cfg_data_i;
      end
    end
  end

  grr_front #(
    .GRID_WIDTH        (GRID_WIDTH),
    .GRID_HEIGHT       (GRID_HEIGHT),
    .SUBTILES_PER_TILE (SUBTILES_PER_TILE),
    .MAX_RECT_SIDE     (MAX_RECT_SIDE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .fine_x_i      (fine_x_i),
    .fine_y_i      (fine_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .map_width_i   (map_width_q),
    .map_height_i  (map_height_q),
    .clearing_i    (clearing),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  grr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_data)
  );

  grr_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (head_data),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top import grr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  // longest request is a done one of MAX_SIDE_DEF rows
  localparam int SETTLE_CYCLES = 2 * MAX_SIDE_DEF + 8;

  localparam logic FUNC_RELEASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef struct {
    logic              func;
    logic [FINE_W-1:0] fx;
    logic [FINE_W-1:0] fy;
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
  } rect_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = 1'b0;
  logic [FINE_W-1:0]   fine_x_i = '0;
  logic [FINE_W-1:0]   fine_y_i = '0;
  logic [RECT_W-1:0]   rect_width_i = '0;
  logic [RECT_W-1:0]   rect_height_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;

  // shadow copy of the occupancy map and the size registers
  bit [GRID_WIDTH_DEF-1:0] tile_rows [GRID_HEIGHT_DEF];
  logic [CFG_W-1:0] map_w = MAP_SIZE_RST;
  logic [CFG_W-1:0] map_h = MAP_SIZE_RST;

  rect_req_t pending_q[$];
  rect_req_t placed_q[$];
  status_e   predicted_status_q[$];
  rect_req_t drv_item;
  status_e   exp_status;

  int  queued_cnt = 0;
  int  accepted_cnt = 0;
  int  errors = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  drv_calm = 1'b0;
  bit  mon_calm = 1'b0;

  grid_rectangle_reserver_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .fine_x_i     (fine_x_i),
    .fine_y_i     (fine_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic status_e reserve_outcome(input rect_req_t r);
    int mw, mh, bx, by;
    mw = (map_w > GRID_WIDTH_DEF) ? GRID_WIDTH_DEF : int'(map_w);
    mh = (map_h > GRID_HEIGHT_DEF) ? GRID_HEIGHT_DEF : int'(map_h);
    bx = int'(r.fx) / SUBTILES_DEF;
    by = int'(r.fy) / SUBTILES_DEF;
    if (r.w == 0 || r.h == 0 || r.w > MAX_SIDE_DEF || r.h > MAX_SIDE_DEF ||
        bx + int'(r.w) > mw || by + int'(r.h) > mh) begin
      return STATUS_BOUNDS;
    end
    // all or nothing: any tile already holding the target mark blocks the lot
    for (int y = 0; y < int'(r.h); y++) begin
      for (int x = 0; x < int'(r.w); x++) begin
        if (tile_rows[by + y][bx + x] == r.func) begin
          return STATUS_CONFLICT;
        end
      end
    end
    for (int y = 0; y < int'(r.h); y++) begin
      for (int x = 0; x < int'(r.w); x++) begin
        tile_rows[by + y][bx + x] = r.func;
      end
    end
    return STATUS_DONE;
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [RECT_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return RECT_W'($urandom_range(1, 4));
    end else if (r < 93) begin
      return RECT_W'($urandom_range(5, MAX_SIDE_DEF));
    end else if (r < 97) begin
      return RECT_W'(MAX_SIDE_DEF);
    end else if (r < 98) begin
      return '0;
    end
    return RECT_W'($urandom_range(MAX_SIDE_DEF + 1, 31));
  endfunction

  // mostly reserve then release pairs over a small window, plus repeats and noise
  function automatic rect_req_t next_request(input int ox, input int oy, input int span);
    rect_req_t r;
    int pick, k, tx, ty;
    pick = $urandom_range(0, 99);
    if (pick < 25 && placed_q.size() != 0) begin
      k = $urandom_range(0, placed_q.size() - 1);
      r = placed_q[k];
      placed_q.delete(k);
      r.func = FUNC_RELEASE;
      return r;
    end
    if (pick < 37 && placed_q.size() != 0) begin
      r = placed_q[$urandom_range(0, placed_q.size() - 1)];
      r.func = FUNC_RESERVE;
      return r;
    end
    if (pick < 45) begin
      r.func = 1'($urandom_range(0, 1));
      r.fx = FINE_W'($urandom_range(0, 1023));
      r.fy = FINE_W'($urandom_range(0, 1023));
      r.w = RECT_W'($urandom_range(0, 31));
      r.h = RECT_W'($urandom_range(0, 31));
      return r;
    end
    tx = ox + $urandom_range(0, span - 1);
    ty = oy + $urandom_range(0, span - 1);
    if (tx > GRID_WIDTH_DEF - 1) tx = GRID_WIDTH_DEF - 1;
    if (ty > GRID_HEIGHT_DEF - 1) ty = GRID_HEIGHT_DEF - 1;
    r.func = (pick < 85) ? FUNC_RESERVE : FUNC_RELEASE;
    r.fx = FINE_W'(tx * SUBTILES_DEF + $urandom_range(0, SUBTILES_DEF - 1));
    r.fy = FINE_W'(ty * SUBTILES_DEF + $urandom_range(0, SUBTILES_DEF - 1));
    r.w = pick_side();
    r.h = pick_side();
    if (r.func == FUNC_RESERVE) begin
      placed_q = {placed_q, r};
      if (placed_q.size() > 48) void'(placed_q.pop_front());
    end
    return r;
  endfunction

  task automatic push_req(input logic func, input int fx, input int fy,
                          input int w, input int h);
    rect_req_t r;
    r.func = func;
    r.fx = FINE_W'(fx);
    r.fy = FINE_W'(fy);
    r.w = RECT_W'(w);
    r.h = RECT_W'(h);
    pending_q = {pending_q, r};
    queued_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_W'(val);
    if (idx == REG_MAP_WIDTH) begin
      map_w = CFG_W'(val);
    end else if (idx == REG_MAP_HEIGHT) begin
      map_h = CFG_W'(val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (accepted_cnt != queued_cnt || predicted_status_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int mw, input int mh, input int ox, input int oy,
                           input int span, input int count);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    placed_q.delete();
    for (int i = 0; i < count; i++) begin
      pending_q = {pending_q, next_request(ox, oy, span)};
      queued_cnt++;
    end
    drain();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i <= 1'b0;
      fine_x_i <= '0;
      fine_y_i <= '0;
      rect_width_i <= '0;
      rect_height_i <= '0;
      gap_left = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        drv_item.func = func_i;
        drv_item.fx = fine_x_i;
        drv_item.fy = fine_y_i;
        drv_item.w = rect_width_i;
        drv_item.h = rect_height_i;
        predicted_status_q = {predicted_status_q, reserve_outcome(drv_item)};
        accepted_cnt++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drv_item = pending_q.pop_front();
        func_i <= drv_item.func;
        fine_x_i <= drv_item.fx;
        fine_y_i <= drv_item.fy;
        rect_width_i <= drv_item.w;
        rect_height_i <= drv_item.h;
        in_valid_i <= 1'b1;
        gap_left = idle_len(drv_calm);
        if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // status monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_status_q.size() == 0) begin
          $error("status: expected none, actual %0d", status_o);
          errors++;
        end else begin
          exp_status = predicted_status_q.pop_front();
          if (status_o !== exp_status) begin
            $error("status: expected %0d, actual %0d", exp_status, status_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = idle_len(mon_calm);
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
        if ($urandom_range(0, 59) == 0) mon_calm = !mon_calm;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("grid_rectangle_reserver_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset-size map: single tiles, far edge, bad sizes, conflicts
    push_req(FUNC_RESERVE, 0, 0, 1, 1);
    push_req(FUNC_RESERVE, 0, 0, 1, 1);
    push_req(FUNC_RELEASE, 0, 0, 1, 1);
    push_req(FUNC_RELEASE, 0, 0, 1, 1);
    push_req(FUNC_RESERVE, 1023, 1023, 1, 1);
    push_req(FUNC_RELEASE, 1020, 1021, 1, 1);
    push_req(FUNC_RESERVE, 963, 962, 16, 16);
    push_req(FUNC_RELEASE, 960, 960, 16, 16);
    push_req(FUNC_RESERVE, 964, 0, 16, 1);
    push_req(FUNC_RESERVE, 0, 964, 1, 16);
    push_req(FUNC_RESERVE, 0, 0, 0, 1);
    push_req(FUNC_RESERVE, 0, 0, 1, 0);
    push_req(FUNC_RESERVE, 0, 0, 17, 1);
    push_req(FUNC_RESERVE, 0, 0, 31, 31);
    push_req(FUNC_RELEASE, 0, 0, 16, 17);
    push_req(FUNC_RESERVE, 40, 40, 1, 1);
    // overlaps the tile above, so nothing may change
    push_req(FUNC_RESERVE, 21, 22, 16, 16);
    push_req(FUNC_RESERVE, 45, 47, 1, 1);
    push_req(FUNC_RESERVE, 1000, 1000, 1, 1);
    // out of bounds and overlapping: bounds wins
    push_req(FUNC_RESERVE, 980, 980, 16, 16);
    push_req(FUNC_RELEASE, 682, 341, 16, 16);
    push_req(FUNC_RESERVE, 682, 341, 16, 16);
    push_req(FUNC_RELEASE, 682, 341, 16, 16);
    drain();

    run_phase(256, 256, 0, 0, 12, 150);
    run_phase(256, 256, 236, 236, 20, 150);
    run_phase(16, 16, 0, 0, 20, 150);
    run_phase(1, 1, 0, 0, 2, 60);
    run_phase(0, 40, 0, 0, 10, 30);
    run_phase(511, 300, 240, 240, 16, 150);
    // unmapped indexes must leave the sizes alone
    write_reg(REG_SPARE2, 5);
    write_reg(REG_SPARE3, 0);
    for (int i = 0; i < 60; i++) begin
      pending_q = {pending_q, next_request(236, 236, 20)};
      queued_cnt++;
    end
    drain();
    run_phase($urandom_range(1, 256), $urandom_range(1, 256), 0, 0, 24, 150);
    run_phase(40, 33, 20, 20, 24, 150);
    run_phase(256, 256, 100, 60, 10, 150);

    if (errors == 0) begin
      $display("grid_rectangle_reserver_core: match");
    end else begin
      $display("grid_rectangle_reserver_core: mismatch");
    end
    $finish;
  end

endmodule
